// File: rtl/rscf_pkg.sv
// Shared types, codes and the sequencer program for the redundant command framer.
// Depends on nothing; rscf_seq and the framer top level in rtl import it.
package rscf_pkg;

    // Host opcodes as carried in the command transaction
    localparam logic [2:0] OP_SET_SPEED   = 3'd0;
    localparam logic [2:0] OP_GET_SPEED   = 3'd1;
    localparam logic [2:0] OP_START       = 3'd2;
    localparam logic [2:0] OP_STOP        = 3'd3;
    localparam logic [2:0] OP_CLEAR_FAULT = 3'd4;
    localparam logic [2:0] OP_GET_FAULT   = 3'd5;
    localparam logic [2:0] OP_LINK        = 3'd6;
    // opcode value with no meaning; always refused
    localparam logic [2:0] OP_UNUSED      = 3'd7;

    // Result kinds
    localparam logic [1:0] KIND_SEND   = 2'd0;
    localparam logic [1:0] KIND_REPLY  = 2'd1;
    localparam logic [1:0] KIND_REFUSE = 2'd2;

    // Configuration register indexes
    localparam int NUM_REGS = 8;
    localparam logic [2:0] REG_LOAD_A      = 3'd0;
    localparam logic [2:0] REG_LOAD_B      = 3'd1;
    localparam logic [2:0] REG_SPEED_RAMP  = 3'd2;
    localparam logic [2:0] REG_GET_SPEED   = 3'd3;
    localparam logic [2:0] REG_START       = 3'd4;
    localparam logic [2:0] REG_STOP        = 3'd5;
    localparam logic [2:0] REG_ACK_FAULTS  = 3'd6;
    localparam logic [2:0] REG_GET_FAULT   = 3'd7;

    localparam logic [7:0] DUMMY_BYTE = 8'h00;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [15:0] speed_rpm;
        logic [15:0]        ramp_ms;
        logic [7:0]         link_byte;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic [15:0] reply_value;
    } rsp_item_t;

    // Datapath actions driven by one control word
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_START,
        ACT_SAMPLE,
        ACT_ADVANCE,
        ACT_EMIT_SEND,
        ACT_EMIT_REPLY,
        ACT_EMIT_REFUSE
    } act_t;

    // Jump conditions; jump taken to target, else fall through
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_NO_CMD,
        COND_REFUSE,
        COND_LINK,
        COND_REP_MORE,
        COND_FRAME_MORE
    } cond_t;

    // Program steps (the step counter)
    typedef enum logic [3:0] {
        S_WAIT     = 4'd0,
        S_CHECK    = 4'd1,
        S_ROUTE    = 4'd2,
        S_START    = 4'd3,
        S_SAMPLE   = 4'd4,
        S_ADVANCE  = 4'd5,
        S_REPLY    = 4'd6,
        S_SEND     = 4'd7,
        S_REFUSE   = 4'd8
    } step_t;

    typedef struct packed {
        act_t  act;
        logic  emit;     // loads the result register; holds if full and stalled
        cond_t cond;
        step_t target;
    } uword_t;

    // Status from datapath to sequencer
    typedef struct packed {
        logic cmd_fire;
        logic refuse;
        logic is_link;
        logic rep_more;
        logic frame_more;
        logic out_free;
    } cond_flags_t;

    // Sequencer to datapath
    typedef struct packed {
        act_t act;
        logic at_wait;
    } seq_ctrl_t;

    // Microcode ROM
    function automatic uword_t ucode(step_t s);
        uword_t w;
        case (s)
            S_WAIT:    w = '{ACT_NONE,        1'b0, COND_NO_CMD,     S_WAIT};
            S_CHECK:   w = '{ACT_NONE,        1'b0, COND_REFUSE,     S_REFUSE};
            S_ROUTE:   w = '{ACT_NONE,        1'b0, COND_LINK,       S_SAMPLE};
            S_START:   w = '{ACT_START,       1'b0, COND_ALWAYS,     S_SEND};
            S_SAMPLE:  w = '{ACT_SAMPLE,      1'b0, COND_REP_MORE,   S_SEND};
            S_ADVANCE: w = '{ACT_ADVANCE,     1'b0, COND_FRAME_MORE, S_SEND};
            S_REPLY:   w = '{ACT_EMIT_REPLY,  1'b1, COND_ALWAYS,     S_WAIT};
            S_SEND:    w = '{ACT_EMIT_SEND,   1'b1, COND_ALWAYS,     S_WAIT};
            S_REFUSE:  w = '{ACT_EMIT_REFUSE, 1'b1, COND_ALWAYS,     S_WAIT};
            default:   w = '{ACT_NONE,        1'b0, COND_ALWAYS,     S_WAIT};
        endcase
        return w;
    endfunction

    // Link bytes in a frame, per command
    function automatic logic [2:0] frame_len(logic [2:0] cmd);
        logic [2:0] n;
        case (cmd)
            OP_SET_SPEED: n = 3'd7;
            OP_GET_SPEED,
            OP_GET_FAULT: n = 3'd3;
            default:      n = 3'd1;
        endcase
        return n;
    endfunction

endpackage

// File: rtl/rscf_vote.sv
// Running majority vote over the repeated answers of one link byte.
// Depends on no package; REPEATS comes from the framer top level.
module rscf_vote
#(
    parameter int REPEATS = 8
) (
    input  logic                  clk,
    input  logic                  sample_en,
    input  logic [((REPEATS > 1) ? $clog2(REPEATS) : 1)-1:0] sample_idx,
    input  logic [7:0]            sample_byte,
    output logic [7:0]            best_byte
);
    localparam int IDX_W = (REPEATS > 1) ? $clog2(REPEATS) : 1;
    localparam int CNT_W = $clog2(REPEATS + 1);

    logic [7:0]       samp_reg [REPEATS];
    logic [7:0]       best_reg;
    logic [CNT_W-1:0] best_cnt_reg;
    logic [IDX_W-1:0] best_first_reg;

    logic [REPEATS-1:0] match;
    logic [CNT_W-1:0]   cnt_v;
    logic [IDX_W-1:0]   first_v;
    logic               take;

    // match against earlier answers of this byte only
    always_comb
    begin
        for (int j = 0; j < REPEATS; j++)
        begin
            match[j] = (IDX_W'(j) < sample_idx) && (samp_reg[j] == sample_byte);
        end
    end

    always_comb
    begin
        first_v = sample_idx;
        for (int j = REPEATS - 1; j >= 0; j--)
        begin
            if (match[j])
            begin
                first_v = IDX_W'(j);
            end
        end
    end

    assign cnt_v = CNT_W'($countones(match)) + CNT_W'(1);

    // new leader on a higher count, or on a tie with an earlier first arrival
    assign take = (sample_idx == '0) || (cnt_v > best_cnt_reg) ||
                  ((cnt_v == best_cnt_reg) && (sample_byte != best_reg) &&
                   (first_v < best_first_reg));

    always_ff @(posedge clk)
    begin
        if (sample_en)
        begin
            samp_reg[sample_idx] <= sample_byte;
            if (take)
            begin
                best_reg       <= sample_byte;
                best_cnt_reg   <= cnt_v;
                best_first_reg <= first_v;
            end
        end
    end

    assign best_byte = best_reg;

endmodule

// File: rtl/rscf_seq.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on rscf_pkg for the program, control word and flag types.
module rscf_seq
    import rscf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cond_flags_t flags,
    output seq_ctrl_t   ctrl
);
    step_t  upc_reg;
    step_t  upc_next;
    uword_t uw;
    logic   hold;
    logic   jump;

    assign uw   = ucode(upc_reg);
    assign hold = uw.emit && !flags.out_free;

    always_comb
    begin
        case (uw.cond)
            COND_ALWAYS:     jump = 1'b1;
            COND_NO_CMD:     jump = !flags.cmd_fire;
            COND_REFUSE:     jump = flags.refuse;
            COND_LINK:       jump = flags.is_link;
            COND_REP_MORE:   jump = flags.rep_more;
            COND_FRAME_MORE: jump = flags.frame_more;
            default:         jump = 1'b1;
        endcase

        if (hold)
        begin
            upc_next = upc_reg;
        end
        else if (jump)
        begin
            upc_next = uw.target;
        end
        else
        begin
            upc_next = step_t'(upc_reg + 4'd1);
        end

        ctrl.act     = hold ? ACT_NONE : uw.act;
        ctrl.at_wait = (upc_reg == S_WAIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= S_WAIT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// File: rtl/redundant_spi_command_framer.sv
// An accepted transaction is checked, then refused, or routed to the start and send steps
// for a command, or for a link byte to sample and send, or after its last repeat to
// advance and then send or reply. The next transaction is taken once the program is
// back at its wait step, even while the previous result sits stalled in the output register.
// Reset: rst_n asynchronous, clears control state, command byte registers and frame state.
// Top level of the redundant command framer; depends on rscf_pkg, rscf_seq, rscf_vote.
module redundant_spi_command_framer
    import rscf_pkg::*;
#(
    parameter int REPEATS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    // host command / link byte transactions
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  cmd_item_t  cmd,
    // results
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output rsp_item_t  rsp,
    // configuration writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);
    localparam int IDX_W = (REPEATS > 1) ? $clog2(REPEATS) : 1;
    localparam int REP_W = $clog2(REPEATS + 1);

    // command byte registers
    logic [7:0]  regs_reg [NUM_REGS];

    // latched transaction
    cmd_item_t   cmd_reg;
    logic        cmd_fire;

    // frame state
    logic        busy_reg;
    logic [2:0]  active_reg;
    logic [2:0]  pos_reg;
    logic [IDX_W-1:0] rep_reg;
    logic [15:0] speed_reg;
    logic [15:0] ramp_reg;
    logic [7:0]  reply_high_reg;
    logic [15:0] reply_word_reg;

    // result register
    logic        rsp_valid_reg;
    rsp_item_t   rsp_reg;

    cond_flags_t flags;
    seq_ctrl_t   ctrl;
    logic [7:0]  voted;
    logic [7:0]  send_byte;
    logic        send_last;
    logic [2:0]  len;
    logic        is_read;
    logic        out_free;

    rscf_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    rscf_vote #(
        .REPEATS (REPEATS)
    ) u_vote (
        .clk         (clk),
        .sample_en   (ctrl.act == ACT_SAMPLE),
        .sample_idx  (rep_reg),
        .sample_byte (cmd_reg.link_byte),
        .best_byte   (voted)
    );

    // Handshakes: commands only at the program's wait step, config always open
    assign cmd_stall = !ctrl.at_wait;
    assign cmd_fire  = cmd_valid && !cmd_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    assign len     = frame_len(active_reg);
    assign is_read = (active_reg == OP_GET_SPEED) || (active_reg == OP_GET_FAULT);

    // Sequencer status
    always_comb
    begin
        flags.cmd_fire   = cmd_fire;
        // command while busy, link byte while idle, or unused opcode
        flags.refuse     = (cmd_reg.opcode == OP_UNUSED) ||
                           ((cmd_reg.opcode == OP_LINK) && !busy_reg) ||
                           ((cmd_reg.opcode != OP_LINK) && busy_reg);
        flags.is_link    = (cmd_reg.opcode == OP_LINK);
        flags.rep_more   = (REP_W'(rep_reg) + REP_W'(1)) < REP_W'(REPEATS);
        flags.frame_more = ({1'b0, pos_reg} + 4'd1) < {1'b0, len};
        flags.out_free   = out_free;
    end

    // Byte to send at the current frame position; looked up at send time
    always_comb
    begin
        send_byte = DUMMY_BYTE;
        case (active_reg)
            OP_SET_SPEED:
            begin
                case (pos_reg)
                    3'd0:    send_byte = regs_reg[REG_LOAD_A];
                    3'd1:    send_byte = speed_reg[15:8];
                    3'd2:    send_byte = speed_reg[7:0];
                    3'd3:    send_byte = regs_reg[REG_LOAD_B];
                    3'd4:    send_byte = ramp_reg[15:8];
                    3'd5:    send_byte = ramp_reg[7:0];
                    default: send_byte = regs_reg[REG_SPEED_RAMP];
                endcase
            end
            OP_GET_SPEED:
                send_byte = (pos_reg == 3'd0) ? regs_reg[REG_GET_SPEED] : DUMMY_BYTE;
            OP_START:       send_byte = regs_reg[REG_START];
            OP_STOP:        send_byte = regs_reg[REG_STOP];
            OP_CLEAR_FAULT: send_byte = regs_reg[REG_ACK_FAULTS];
            OP_GET_FAULT:
                send_byte = (pos_reg == 3'd0) ? regs_reg[REG_GET_FAULT] : DUMMY_BYTE;
            default:        send_byte = DUMMY_BYTE;
        endcase
        send_last = ({1'b0, pos_reg} + 4'd1) == {1'b0, len};
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                regs_reg[i] <= 8'h00;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            regs_reg[cfg_index] <= cfg_data;
        end
    end

    // Input latch
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            cmd_reg <= cmd;
        end
    end

    // Frame datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            active_reg     <= OP_SET_SPEED;
            pos_reg        <= 3'd0;
            rep_reg        <= '0;
            speed_reg      <= 16'h0000;
            ramp_reg       <= 16'h0000;
            reply_high_reg <= 8'h00;
            reply_word_reg <= 16'h0000;
        end
        else
        begin
            case (ctrl.act)
                ACT_START:
                begin
                    busy_reg       <= 1'b1;
                    active_reg     <= cmd_reg.opcode;
                    pos_reg        <= 3'd0;
                    rep_reg        <= '0;
                    reply_word_reg <= 16'h0000;
                    if (cmd_reg.opcode == OP_SET_SPEED)
                    begin
                        speed_reg <= cmd_reg.speed_rpm;
                        ramp_reg  <= cmd_reg.ramp_ms;
                    end
                end
                ACT_SAMPLE:
                begin
                    rep_reg <= flags.rep_more ? IDX_W'(REP_W'(rep_reg) + REP_W'(1)) : '0;
                end
                ACT_ADVANCE:
                begin
                    // voted word is complete here
                    if (is_read && (pos_reg == 3'd1))
                    begin
                        reply_high_reg <= voted;
                    end
                    if (is_read && (pos_reg == 3'd2))
                    begin
                        reply_word_reg <= {reply_high_reg, voted};
                    end
                    pos_reg  <= flags.frame_more ? (pos_reg + 3'd1) : 3'd0;
                    busy_reg <= flags.frame_more;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result register: loads on an emit step, drains on a taken transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if ((ctrl.act == ACT_EMIT_SEND) || (ctrl.act == ACT_EMIT_REPLY) ||
                 (ctrl.act == ACT_EMIT_REFUSE))
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.act)
            ACT_EMIT_SEND:   rsp_reg <= '{KIND_SEND, send_byte, send_last, 16'h0000};
            ACT_EMIT_REPLY:  rsp_reg <= '{KIND_REPLY, 8'h00, 1'b0, reply_word_reg};
            ACT_EMIT_REFUSE: rsp_reg <= '{KIND_REFUSE, 8'h00, 1'b0, 16'h0000};
            default:
            begin
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // an accepted transaction closes the command port until the program returns
    a_cmd_closes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> cmd_stall)
        else $error("command port open right after a transaction");

    // frame position stays inside the active frame
    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ({1'b0, pos_reg} < {1'b0, len}))
        else $error("frame position past frame end");

    // idle means no partial frame or repeat count left behind
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (pos_reg == 3'd0) && (rep_reg == '0))
        else $error("leftover frame state while idle");

    // repeat counter never reaches REPEATS
    a_rep_range: assert property (@(posedge clk) disable iff (!rst_n)
        REP_W'(rep_reg) < REP_W'(REPEATS))
        else $error("repeat count out of range");

endmodule

// File: test/rscf_tb_pkg.sv
// Frame tracker for the redundant command framer testbench: predicts each result
// and checks what the block returns. Depends on rscf_pkg for structs and codes.
`timescale 1ns / 100ps
package rscf_tb_pkg;
    import rscf_pkg::*;

    class frame_tracker #(int REPS = 8);
        logic [7:0]  cmd_bytes [NUM_REGS];
        bit          busy;
        logic [2:0]  cur_op;
        int          frame_idx;
        int          rep_idx;
        logic [15:0] speed_word;
        logic [15:0] ramp_word;
        logic [7:0]  answers [REPS];
        logic [7:0]  word_high;
        rsp_item_t   rsp_due [$];
        int          mismatches;

        function new();
            foreach (cmd_bytes[i])
                cmd_bytes[i] = 8'h00;
            foreach (answers[i])
                answers[i] = 8'h00;
            busy       = 1'b0;
            cur_op     = OP_SET_SPEED;
            frame_idx  = 0;
            rep_idx    = 0;
            speed_word = 16'h0000;
            ramp_word  = 16'h0000;
            word_high  = 8'h00;
            mismatches = 0;
        endfunction

        function void set_cmd_byte(logic [2:0] idx, logic [7:0] val);
            cmd_bytes[idx] = val;
        endfunction

        function int pending();
            return rsp_due.size();
        endfunction

        function int frame_span(logic [2:0] op);
            if (op == OP_SET_SPEED)
                return 7;
            if (op == OP_GET_SPEED || op == OP_GET_FAULT)
                return 3;
            return 1;
        endfunction

        // byte on the link for the current frame position, looked up now
        function logic [7:0] frame_byte();
            logic [7:0] b;
            b = 8'h00;
            case (cur_op)
                OP_SET_SPEED:
                    case (frame_idx)
                        0:       b = cmd_bytes[REG_LOAD_A];
                        1:       b = speed_word[15:8];
                        2:       b = speed_word[7:0];
                        3:       b = cmd_bytes[REG_LOAD_B];
                        4:       b = ramp_word[15:8];
                        5:       b = ramp_word[7:0];
                        default: b = cmd_bytes[REG_SPEED_RAMP];
                    endcase
                OP_GET_SPEED:   b = (frame_idx == 0) ? cmd_bytes[REG_GET_SPEED] : DUMMY_BYTE;
                OP_START:       b = cmd_bytes[REG_START];
                OP_STOP:        b = cmd_bytes[REG_STOP];
                OP_CLEAR_FAULT: b = cmd_bytes[REG_ACK_FAULTS];
                OP_GET_FAULT:   b = (frame_idx == 0) ? cmd_bytes[REG_GET_FAULT] : DUMMY_BYTE;
                default:        b = 8'h00;
            endcase
            return b;
        endfunction

        function rsp_item_t send_item();
            rsp_item_t r;
            r          = '0;
            r.out_kind = KIND_SEND;
            r.tx_byte  = frame_byte();
            r.tx_last  = (frame_idx + 1 == frame_span(cur_op));
            return r;
        endfunction

        // most frequent answer; on a tie the one that showed up first
        function logic [7:0] majority();
            int         best_n;
            int         n;
            logic [7:0] best;
            best_n = 0;
            best   = 8'h00;
            for (int i = 0; i < REPS; i++)
            begin
                n = 0;
                for (int j = 0; j < REPS; j++)
                    if (answers[j] == answers[i])
                        n++;
                if (n > best_n)
                begin
                    best_n = n;
                    best   = answers[i];
                end
            end
            return best;
        endfunction

        function void note_command(cmd_item_t c);
            rsp_item_t   r;
            logic [7:0]  v;
            logic [15:0] word;
            r          = '0;
            r.out_kind = KIND_REFUSE;
            word       = 16'h0000;
            if (c.opcode <= OP_GET_FAULT)
            begin
                if (!busy)
                begin
                    busy      = 1'b1;
                    cur_op    = c.opcode;
                    frame_idx = 0;
                    rep_idx   = 0;
                    if (c.opcode == OP_SET_SPEED)
                    begin
                        speed_word = c.speed_rpm;
                        ramp_word  = c.ramp_ms;
                    end
                    r = send_item();
                end
            end
            else if (c.opcode == OP_LINK && busy)
            begin
                answers[rep_idx] = c.link_byte;
                if (rep_idx + 1 < REPS)
                begin
                    rep_idx++;
                    r = send_item();
                end
                else
                begin
                    v       = majority();
                    rep_idx = 0;
                    if (cur_op == OP_GET_SPEED || cur_op == OP_GET_FAULT)
                    begin
                        if (frame_idx == 1)
                            word_high = v;
                        if (frame_idx == 2)
                            word = {word_high, v};
                    end
                    frame_idx++;
                    if (frame_idx < frame_span(cur_op))
                        r = send_item();
                    else
                    begin
                        busy          = 1'b0;
                        frame_idx     = 0;
                        r.out_kind    = KIND_REPLY;
                        r.reply_value = word;
                    end
                end
            end
            rsp_due.push_back(r);
        endfunction

        function void flag(string what, rsp_item_t want, rsp_item_t got);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t %s: want kind %0d byte %02h last %0b reply %04h",
                         $time, what, want.out_kind, want.tx_byte, want.tx_last,
                         want.reply_value);
                $display("    got kind %0d byte %02h last %0b reply %04h",
                         got.out_kind, got.tx_byte, got.tx_last, got.reply_value);
            end
        endfunction

        function void check_rsp(rsp_item_t got);
            rsp_item_t want;
            if (rsp_due.size() == 0)
            begin
                flag("result with nothing pending", '0, got);
                return;
            end
            want = rsp_due.pop_front();
            if (got.out_kind !== want.out_kind || got.tx_byte !== want.tx_byte ||
                got.tx_last !== want.tx_last || got.reply_value !== want.reply_value)
                flag("result mismatch", want, got);
        endfunction
    endclass

endpackage

// File: test/testbench.sv
// Top-level testbench for redundant_spi_command_framer: directed and random command
// and link-byte traffic with random idling, checked by rscf_tb_pkg::frame_tracker.
// Depends on rscf_pkg, rscf_tb_pkg and the framer RTL.
`timescale 1ns / 100ps
module testbench;
    import rscf_pkg::*;
    import rscf_tb_pkg::*;

    localparam int LINK_REPEATS = 8;
    localparam int RANDOM_ITEMS = 650;
    localparam int PHASES       = 4;
    // Longest legal quiet stretch is the receiver hold-off plus a long sender gap,
    // so this sits well above that.
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 150;   // results seen before the long hold-off
    localparam int SETTLE       = 12;    // slack after the last result in drain
    localparam int TAIL         = 20;

    // how the command bytes are loaded between phases
    typedef enum int {
        CFG_DISTINCT,
        CFG_ZEROS,
        CFG_ONES,
        CFG_RANDOM
    } cfg_setting_t;

    typedef rscf_tb_pkg::frame_tracker #(LINK_REPEATS) tracker_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cmd_valid;
    logic       cmd_stall;
    cmd_item_t  cmd;
    logic       rsp_valid;
    logic       rsp_stall;
    rsp_item_t  rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    tracker_t   track = new();

    bit         tx_gappy;     // sender idles between transactions when set
    int         grp_style;    // answer pattern for the current repeat group
    logic [7:0] grp_major;
    logic [7:0] grp_minor;

    redundant_spi_command_framer #(
        .REPEATS(LINK_REPEATS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap(bit gappy);
        int roll;
        if (!gappy)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // 16-bit field value, with the corners picked often enough to matter
    function automatic logic [15:0] pick_word();
        if ($urandom_range(0, 9) == 0)
            case ($urandom_range(0, 3))
                0:       return 16'h8000;
                1:       return 16'h7FFF;
                2:       return 16'h0000;
                default: return 16'hFFFF;
            endcase
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic cmd_item_t make_cmd(logic [2:0] op, logic [15:0] spd,
                                           logic [15:0] ramp, logic [7:0] lb);
        cmd_item_t it;
        it.opcode    = op;
        it.speed_rpm = spd;
        it.ramp_ms   = ramp;
        it.link_byte = lb;
        return it;
    endfunction

    // One answer for the current repeat group. Styles give a clear majority,
    // two-way near ties, answers drawn from a tiny alphabet (many ties), or a
    // clean link where every repeat agrees.
    function automatic logic [7:0] link_answer();
        case (grp_style)
            0:       return ($urandom_range(0, 99) < 75) ? grp_major : 8'($urandom_range(0, 255));
            1:       return $urandom_range(0, 1) ? grp_major : grp_minor;
            2:       return 8'($urandom_range(0, 3));
            default: return grp_major;
        endcase
    endfunction

    // Next transaction. The tracker is current, since the driver notes each accepted
    // transaction before asking for the next one. Idle: mostly new commands, some
    // stray link bytes and unused opcodes. Busy: mostly the link answers the frame
    // waits for, with commands and unused opcodes thrown in to be refused.
    function automatic cmd_item_t next_cmd();
        cmd_item_t it;
        int        roll;
        it   = make_cmd(OP_LINK, pick_word(), pick_word(), 8'($urandom_range(0, 255)));
        roll = $urandom_range(0, 99);
        if (!track.busy)
        begin
            if (roll < 85)
                it.opcode = 3'($urandom_range(OP_SET_SPEED, OP_GET_FAULT));
            else if (roll >= 93)
                it.opcode = OP_UNUSED;
        end
        else if (roll < 90)
        begin
            if (track.rep_idx == 0)
            begin
                grp_style = $urandom_range(0, 3);
                grp_major = 8'($urandom_range(0, 255));
                grp_minor = 8'($urandom_range(0, 255));
            end
            it.link_byte = link_answer();
        end
        else if (roll < 96)
            it.opcode = 3'($urandom_range(OP_SET_SPEED, OP_GET_FAULT));
        else
            it.opcode = OP_UNUSED;
        return it;
    endfunction

    // Offer one transaction and hold it until the block takes it. Valid stays high
    // into the next transaction when there is no gap.
    task automatic drive_cmd(input cmd_item_t it);
        int gap;
        gap = pick_gap(tx_gappy);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd       <= it;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        track.note_command(it);
    endtask

    // Stop offering and wait until every result has come back, plus some slack.
    task automatic drain();
        cmd_valid <= 1'b0;
        while (track.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write all eight command bytes back to back; only called with the block drained.
    task automatic load_cmd_bytes(input cfg_setting_t setting);
        logic [7:0] v;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            case (setting)
                CFG_DISTINCT: v = 8'hA0 + 8'(i);
                CFG_ZEROS:    v = 8'h00;
                CFG_ONES:     v = 8'hFF;
                default:      v = 8'($urandom_range(0, 255));
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= v;
            do
                @(posedge clk);
            while (!cfg_ready);
            track.set_cmd_byte(3'(i), v);
        end
        cfg_valid <= 1'b0;
    endtask

    // Receiving side: checks every accepted result and drives rsp_stall. Idling
    // switches on and off in stretches; once, after enough results, it holds off
    // for a long stretch so the block backs up and stalls the command side.
    initial
    begin : rsp_side
        int seen;
        int stall_left;
        int hold_left;
        int cycle_n;
        bit hold_done;
        bit rx_gappy;
        seen       = 0;
        stall_left = 0;
        hold_left  = 0;
        cycle_n    = 0;
        hold_done  = 1'b0;
        rx_gappy   = 1'b1;
        rsp_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            cycle_n++;
            if (rsp_valid && !rsp_stall)
            begin
                track.check_rsp(rsp);
                seen++;
            end
            if (cycle_n % 256 == 0)
                rx_gappy = 1'($urandom_range(0, 1));
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (!hold_done && seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                rsp_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if (rx_gappy && $urandom_range(0, 99) < 30)
            begin
                stall_left = pick_gap(1'b1);
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Watchdog: too many cycles with no transaction on any channel ends the run.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("** redundant_spi_command_framer: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        // four values twice each: a full tie, the first arrival must win
        static logic [7:0]   tie_bytes [LINK_REPEATS] = '{8'h55, 8'hAA, 8'hAA, 8'h55,
                                                          8'h00, 8'hFF, 8'h00, 8'hFF};
        // all different: again the first arrival wins
        static logic [7:0]   odd_bytes [LINK_REPEATS] = '{8'h01, 8'h02, 8'h04, 8'h08,
                                                          8'h10, 8'h20, 8'h40, 8'h80};
        static cfg_setting_t phase_cfg [PHASES] = '{CFG_ONES, CFG_ZEROS, CFG_RANDOM,
                                                    CFG_RANDOM};
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        cfg_valid = 1'b0;
        cfg_index = 3'd0;
        cfg_data  = 8'h00;
        tx_gappy  = 1'b0;
        grp_style = 0;
        grp_major = 8'h00;
        grp_minor = 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_cmd_bytes(CFG_DISTINCT);

        // Directed: refusals while idle and busy, both voting tie cases, and a
        // set speed at the field extremes that the random part then carries on.
        drive_cmd(make_cmd(OP_LINK, 16'h0000, 16'h0000, 8'h3C));     // stray link byte
        drive_cmd(make_cmd(OP_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF));
        drive_cmd(make_cmd(OP_START, 16'h0000, 16'h0000, 8'h00));
        drive_cmd(make_cmd(OP_STOP, 16'h0000, 16'h0000, 8'h00));     // busy: refused
        drive_cmd(make_cmd(OP_UNUSED, 16'h0000, 16'h0000, 8'h00));
        foreach (tie_bytes[i])
            drive_cmd(make_cmd(OP_LINK, 16'h0000, 16'h0000, tie_bytes[i]));
        drive_cmd(make_cmd(OP_STOP, 16'h0000, 16'h0000, 8'h00));
        foreach (odd_bytes[i])
            drive_cmd(make_cmd(OP_LINK, 16'hFFFF, 16'hFFFF, odd_bytes[i]));
        drive_cmd(make_cmd(OP_SET_SPEED, 16'h8000, 16'hFFFF, 8'h00));
        // refused while busy; must not disturb the latched speed and ramp
        drive_cmd(make_cmd(OP_GET_FAULT, 16'h7FFF, 16'h0000, 8'hFF));

        // Random phases. The command bytes change between phases, often with a
        // frame still open, so a new value must show up on the following sends.
        for (int p = 0; p < PHASES; p++)
        begin
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
            begin
                if (n % 64 == 0)
                    tx_gappy = 1'($urandom_range(0, 1));
                drive_cmd(next_cmd());
            end
            drain();
            load_cmd_bytes(phase_cfg[p]);
        end

        // close out: keep answering until any open frame has replied
        while (track.busy)
            drive_cmd(next_cmd());
        drain();
        repeat (TAIL) @(posedge clk);

        if (track.mismatches == 0 && track.pending() == 0)
            $display("** redundant_spi_command_framer: PASSED **");
        else
        begin
            $display("mismatches %0d, results never seen %0d",
                     track.mismatches, track.pending());
            $display("** redundant_spi_command_framer: FAILED **");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/rscf_pkg.sv
rtl/rscf_vote.sv
rtl/rscf_seq.sv
rtl/redundant_spi_command_framer.sv
test/rscf_tb_pkg.sv
test/testbench.sv
